>>> rtl/pld_pkg.sv
// ----------------------------------------------------------------------------
// pld_pkg: shared widths and types for the point-to-line distance core
// Holds the coordinate width and every width that follows from it, plus the
// stage count of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

  // Width of one coordinate. The fraction point position does not enter the
  // arithmetic: the result has the same scale as the raw inputs.
  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;

  localparam int V_W    = CW + 1;            // line point minus query point
  localparam int P_W    = 2 * CW + 1;        // one cross-product term
  localparam int N_W    = 2 * CW + 2;        // one cross-product component
  localparam int MAG_W  = 2 * CW + 1;        // magnitude of a component
  localparam int LO_W   = (MAG_W + 1) / 2;   // low half of a magnitude
  localparam int HI_W   = MAG_W - LO_W;      // high half of a magnitude
  localparam int DD_W   = 2 * CW;            // squared length of the direction
  localparam int NN_W   = 4 * CW + 2;        // squared length of the cross product
  localparam int T_W    = 3 * CW;            // partial root times DD_W value

  // Three cross stages, four norm stages, one root setup stage, one stage
  // per result bit and the output stage.
  localparam int NSTAGE = CW + 9;
  localparam int ROOT_FIRST = 7;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [N_W-1:0] cross_t;
  typedef logic [DD_W-1:0]       dsq_t;
  typedef logic [NN_W-1:0]       nsq_t;

endpackage

`default_nettype wire

>>> rtl/pld_cross.sv
// ----------------------------------------------------------------------------
// pld_cross: difference vector, cross product and squared direction length
// Three register stages: subtract, multiply, combine.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_cross (
  input  wire logic              clk_i,
  input  wire logic [2:0]        en_i,
  input  wire pld_pkg::coord_t   line_i  [3],
  input  wire pld_pkg::coord_t   dir_i   [3],
  input  wire pld_pkg::coord_t   query_i [3],
  output pld_pkg::cross_t        n_o     [3],
  output pld_pkg::dsq_t          dd_o
);

  logic signed [pld_pkg::V_W-1:0] v_q [3];
  pld_pkg::coord_t                d_q [3];
  logic signed [pld_pkg::P_W-1:0] prod_q [6];
  pld_pkg::dsq_t                  dsq_q [3];
  pld_pkg::cross_t                n_q [3];
  pld_pkg::dsq_t                  dd_q;

  // Stage one: the vector from the query point to the line point.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= pld_pkg::V_W'(line_i[i]) - pld_pkg::V_W'(query_i[i]);
        d_q[i] <= dir_i[i];
      end
    end
  end

  // Stage two: the six cross terms and the three direction squares.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q[0] <= pld_pkg::P_W'(v_q[1]) * pld_pkg::P_W'(d_q[2]);
      prod_q[1] <= pld_pkg::P_W'(v_q[2]) * pld_pkg::P_W'(d_q[1]);
      prod_q[2] <= pld_pkg::P_W'(v_q[2]) * pld_pkg::P_W'(d_q[0]);
      prod_q[3] <= pld_pkg::P_W'(v_q[0]) * pld_pkg::P_W'(d_q[2]);
      prod_q[4] <= pld_pkg::P_W'(v_q[0]) * pld_pkg::P_W'(d_q[1]);
      prod_q[5] <= pld_pkg::P_W'(v_q[1]) * pld_pkg::P_W'(d_q[0]);
      for (int i = 0; i < 3; i++) begin
        dsq_q[i] <= pld_pkg::DD_W'(pld_pkg::DD_W'(d_q[i]) * pld_pkg::DD_W'(d_q[i]));
      end
    end
  end

  // Stage three: the cross product components and the squared direction length.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n_q[0] <= pld_pkg::N_W'(prod_q[0]) - pld_pkg::N_W'(prod_q[1]);
      n_q[1] <= pld_pkg::N_W'(prod_q[2]) - pld_pkg::N_W'(prod_q[3]);
      n_q[2] <= pld_pkg::N_W'(prod_q[4]) - pld_pkg::N_W'(prod_q[5]);
      dd_q   <= dsq_q[0] + dsq_q[1] + dsq_q[2];
    end
  end

  assign n_o  = n_q;
  assign dd_o = dd_q;

endmodule

`default_nettype wire

>>> rtl/pld_norm.sv
// ----------------------------------------------------------------------------
// pld_norm: squared length of the cross product
// Four register stages: magnitude, half-width partial products, per-component
// square, sum of the three squares. The squared direction length rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_norm (
  input  wire logic              clk_i,
  input  wire logic [3:0]        en_i,
  input  wire pld_pkg::cross_t   n_i [3],
  input  wire pld_pkg::dsq_t     dd_i,
  output pld_pkg::nsq_t          nn_o,
  output pld_pkg::dsq_t          dd_o
);

  localparam int LO_W = pld_pkg::LO_W;
  localparam int HI_W = pld_pkg::HI_W;

  logic [pld_pkg::MAG_W-1:0] mag_q [3];
  logic [2*HI_W-1:0]         hh_q [3];
  logic [HI_W+LO_W-1:0]      hl_q [3];
  logic [2*LO_W-1:0]         ll_q [3];
  pld_pkg::nsq_t             sq_q [3];
  pld_pkg::nsq_t             nn_q;
  pld_pkg::dsq_t             dd_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= n_i[i][pld_pkg::N_W-1] ? pld_pkg::MAG_W'(-n_i[i])
                                           : pld_pkg::MAG_W'(n_i[i]);
      end
      dd_q[0] <= dd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= (2*HI_W)'(mag_q[i][pld_pkg::MAG_W-1:LO_W])
                 * (2*HI_W)'(mag_q[i][pld_pkg::MAG_W-1:LO_W]);
        hl_q[i] <= (HI_W+LO_W)'(mag_q[i][pld_pkg::MAG_W-1:LO_W])
                 * (HI_W+LO_W)'(mag_q[i][LO_W-1:0]);
        ll_q[i] <= (2*LO_W)'(mag_q[i][LO_W-1:0]) * (2*LO_W)'(mag_q[i][LO_W-1:0]);
      end
      dd_q[1] <= dd_q[0];
    end
  end

  // The square of hi * 2^LO_W + lo, with the middle term counted twice.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (pld_pkg::NN_W'(hh_q[i]) << (2*LO_W))
                 + (pld_pkg::NN_W'(hl_q[i]) << (LO_W+1))
                 + pld_pkg::NN_W'(ll_q[i]);
      end
      dd_q[2] <= dd_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      nn_q    <= sq_q[0] + sq_q[1] + sq_q[2];
      dd_q[3] <= dd_q[2];
    end
  end

  assign nn_o = nn_q;
  assign dd_o = dd_q[3];

endmodule

`default_nettype wire

>>> rtl/pld_root.sv
// ----------------------------------------------------------------------------
// pld_root: integer square root of a quotient, one result bit per stage
// Finds the largest r with r*r*DD <= NN by restoring trial subtraction. The
// remainder NN - r*r*DD and the product r*DD are carried so that each stage
// needs one wide subtract and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_root (
  input  wire logic                     clk_i,
  input  wire logic [pld_pkg::CW+1:0]   en_i,
  input  wire pld_pkg::nsq_t            nn_i,
  input  wire pld_pkg::dsq_t            dd_i,
  output logic [pld_pkg::CW-1:0]        distance_o,
  output logic                          degenerate_o,
  output logic                          saturated_o
);

  localparam int CW   = pld_pkg::CW;
  localparam int NN_W = pld_pkg::NN_W;
  localparam int T_W  = pld_pkg::T_W;

  pld_pkg::nsq_t   rem_q  [CW+1];
  logic [T_W-1:0]  t_q    [CW+1];
  pld_pkg::dsq_t   dd_q   [CW+1];
  logic [CW-1:0]   root_q [CW+1];
  logic            sat_q  [CW+1];
  logic            deg_q  [CW+1];

  // Setup: the distance overflows when NN >= DD * 2^(2*CW).
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= nn_i;
      t_q[0]    <= '0;
      dd_q[0]   <= dd_i;
      root_q[0] <= '0;
      sat_q[0]  <= nn_i >= (NN_W'(dd_i) << (2*CW));
      deg_q[0]  <= dd_i == '0;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_bit
    localparam int B = CW - k;
    pld_pkg::nsq_t  sub;
    logic [NN_W:0]  diff;

    // Raising r by 2^B raises r*r*DD by ((2*r*DD + DD*2^B) * 2^B).
    assign sub  = ((NN_W'(t_q[k-1]) << 1) + (NN_W'(dd_q[k-1]) << B)) << B;
    assign diff = {1'b0, rem_q[k-1]} - {1'b0, sub};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        if (!diff[NN_W]) begin
          rem_q[k]  <= diff[NN_W-1:0];
          t_q[k]    <= t_q[k-1] + (T_W'(dd_q[k-1]) << B);
          root_q[k] <= root_q[k-1] | (CW'(1) << B);
        end else begin
          rem_q[k]  <= rem_q[k-1];
          t_q[k]    <= t_q[k-1];
          root_q[k] <= root_q[k-1];
        end
        dd_q[k]  <= dd_q[k-1];
        sat_q[k] <= sat_q[k-1];
        deg_q[k] <= deg_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[CW+1]) begin
      degenerate_o <= deg_q[CW];
      saturated_o  <= sat_q[CW] && !deg_q[CW];
      if (deg_q[CW]) begin
        distance_o <= '0;
      end else if (sat_q[CW]) begin
        distance_o <= '1;
      end else begin
        distance_o <= root_q[CW];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/point_line_distance_3d_core.sv
// ----------------------------------------------------------------------------
// point_line_distance_3d_core: perpendicular distance from a point to a line
// Streams line/query words in and distance words out, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one word per item: a point on the line, the line
// direction and the query point, each coordinate signed fixed point. A word is
// taken at a rising edge where valid_i is high and stall_o is low.
// The output channel carries distance_o (unsigned, same scale as the inputs,
// truncated), degenerate_o (zero direction, distance zero) and saturated_o
// (distance beyond the output range, distance all ones). A word is taken where
// valid_o is high and stall_i is low.
// A word passes through the cross product stages, the stages for its squared
// length, the root setup stage, a square-root stage for each result bit, and
// the output register.
// Throughput is one word per cycle unless stalled; every stage is a plain register stage.
// Each stage carries a valid bit and moves when the stage after it is empty
// or moving, so a stall on the output fills bubbles first and stall_o rises
// only when every stage holds a word. Nothing is dropped or repeated.
// Reset clears the valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module point_line_distance_3d_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        stall_o,
  input  wire pld_pkg::coord_t        line_x_i,
  input  wire pld_pkg::coord_t        line_y_i,
  input  wire pld_pkg::coord_t        line_z_i,
  input  wire pld_pkg::coord_t        dir_x_i,
  input  wire pld_pkg::coord_t        dir_y_i,
  input  wire pld_pkg::coord_t        dir_z_i,
  input  wire pld_pkg::coord_t        query_x_i,
  input  wire pld_pkg::coord_t        query_y_i,
  input  wire pld_pkg::coord_t        query_z_i,
  output logic                        valid_o,
  input  wire logic                   stall_i,
  output logic [pld_pkg::CW-1:0]      distance_o,
  output logic                        degenerate_o,
  output logic                        saturated_o
);

  localparam int NST = pld_pkg::NSTAGE;
  localparam int RF  = pld_pkg::ROOT_FIRST;

  logic [NST-1:0]  valid_q;
  logic [NST:0]    ready;
  logic [NST-1:0]  en;

  pld_pkg::coord_t line_v [3];
  pld_pkg::coord_t dir_v  [3];
  pld_pkg::coord_t query_v[3];
  pld_pkg::cross_t n_w    [3];
  pld_pkg::dsq_t   dd_cross;
  pld_pkg::dsq_t   dd_norm;
  pld_pkg::nsq_t   nn_w;

  assign line_v  = '{line_x_i, line_y_i, line_z_i};
  assign dir_v   = '{dir_x_i, dir_y_i, dir_z_i};
  assign query_v = '{query_x_i, query_y_i, query_z_i};

  // A stage may load when it is empty or its word moves on this cycle.
  assign ready[NST] = !stall_i;
  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign ready[k] = !valid_q[k] || ready[k+1];
    assign en[k]    = ready[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? valid_i : valid_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign stall_o = !ready[0];
  assign valid_o = valid_q[NST-1];

  pld_cross u_cross (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .line_i  (line_v),
    .dir_i   (dir_v),
    .query_i (query_v),
    .n_o     (n_w),
    .dd_o    (dd_cross)
  );

  pld_norm u_norm (
    .clk_i (clk_i),
    .en_i  (en[RF-1:3]),
    .n_i   (n_w),
    .dd_i  (dd_cross),
    .nn_o  (nn_w),
    .dd_o  (dd_norm)
  );

  pld_root u_root (
    .clk_i        (clk_i),
    .en_i         (en[NST-1:RF]),
    .nn_i         (nn_w),
    .dd_i         (dd_norm),
    .distance_o   (distance_o),
    .degenerate_o (degenerate_o),
    .saturated_o  (saturated_o)
  );

endmodule

`default_nettype wire

>>> rtl/pld_checker.sv
// ----------------------------------------------------------------------------
// pld_checker: port-level checks for the point-to-line distance core
// Watches the output channel and the consistency of the result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pld_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   valid_o,
  input wire logic                   stall_i,
  input wire logic [pld_pkg::CW-1:0] distance_o,
  input wire logic                   degenerate_o,
  input wire logic                   saturated_o
);

  // A zero direction always reports a zero distance.
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> distance_o == '0)
    else $error("degenerate word with nonzero distance");

  // An overflowing distance reports the largest code.
  a_sat_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> distance_o == '1)
    else $error("saturated word without full-scale distance");

  // The two flags never come together.
  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(degenerate_o && saturated_o))
    else $error("degenerate and saturated both set");

  // A stalled result stays in place.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(distance_o))
    else $error("stalled result changed or vanished");

endmodule

bind point_line_distance_3d_core pld_checker u_pld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .distance_o   (distance_o),
  .degenerate_o (degenerate_o),
  .saturated_o  (saturated_o)
);

`default_nettype wire

>>> tb/sv/point_line_distance_3d_core_test.sv
// ----------------------------------------------------------------------------
// point_line_distance_3d_core_test: self-checking bench for the distance core
// Streams line/direction/query words through the core, predicts each distance
// with exact wide integer arithmetic and compares every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected distance words, kept in the order their inputs were accepted.
class distance_scoreboard;
  typedef struct packed {
    logic [pld_pkg::CW-1:0] dist_val;
    logic                   degen;
    logic                   sat;
  } dist_word_t;

  dist_word_t pending[$];
  int         errors;

  // Integer square root by bit-wise search of floor(sqrt(nn / dd)):
  // the largest r with r*r*dd <= nn.
  function automatic dist_word_t solve_distance(pld_pkg::coord_t lx, ly, lz,
                                                dx, dy, dz, qx, qy, qz);
    logic signed [255:0] vx, vy, vz, ex, ey, ez, nx, ny, nz, nn, dd, cand, tst;
    dist_word_t w;
    logic [32:0] r;
    vx = 256'(signed'(lx)) - 256'(signed'(qx));
    vy = 256'(signed'(ly)) - 256'(signed'(qy));
    vz = 256'(signed'(lz)) - 256'(signed'(qz));
    ex = 256'(signed'(dx));
    ey = 256'(signed'(dy));
    ez = 256'(signed'(dz));
    nx = vy * ez - vz * ey;
    ny = vz * ex - vx * ez;
    nz = vx * ey - vy * ex;
    nn = nx * nx + ny * ny + nz * nz;
    dd = ex * ex + ey * ey + ez * ez;
    w = '0;
    if (dd == 0) begin
      w.degen = 1'b1;
      return w;
    end
    cand = 256'(1) << pld_pkg::CW;
    if (cand * cand * dd <= nn) begin
      w.dist_val = '1;
      w.sat      = 1'b1;
      return w;
    end
    r = '0;
    for (int b = pld_pkg::CW - 1; b >= 0; b--) begin
      cand = 256'(r | (33'(1) << b));
      tst  = cand * cand * dd;
      if (tst <= nn) r = cand[32:0];
    end
    w.dist_val = r[pld_pkg::CW-1:0];
    return w;
  endfunction

  function void note_input(pld_pkg::coord_t lx, ly, lz, dx, dy, dz, qx, qy, qz);
    pending.push_back(solve_distance(lx, ly, lz, dx, dy, dz, qx, qy, qz));
  endfunction

  function void check_output(logic [pld_pkg::CW-1:0] dist_val, logic degen, logic sat);
    dist_word_t e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: output word with nothing expected");
      return;
    end
    e = pending.pop_front();
    if (e.dist_val !== dist_val || e.degen !== degen || e.sat !== sat) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: exp dist %h degen %b sat %b, got dist %h degen %b sat %b",
                 e.dist_val, e.degen, e.sat, dist_val, degen, sat);
    end
  endfunction
endclass

module point_line_distance_3d_core_test;

  localparam int LATENCY    = pld_pkg::NSTAGE;
  localparam int IDLE_LIMIT = 2000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   stall_i = 1'b0;
  pld_pkg::coord_t line_x_i = '0, line_y_i = '0, line_z_i = '0;
  pld_pkg::coord_t dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  pld_pkg::coord_t query_x_i = '0, query_y_i = '0, query_z_i = '0;
  logic   stall_o, valid_o, degenerate_o, saturated_o;
  logic [pld_pkg::CW-1:0] distance_o;

  // Idle percentages of the sender and the receiver for the current phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;
  int words_in      = 0;
  int words_out     = 0;
  int n_degen       = 0;
  int n_sat         = 0;

  distance_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  point_line_distance_3d_core dut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .line_x_i, .line_y_i, .line_z_i,
    .dir_x_i, .dir_y_i, .dir_z_i,
    .query_x_i, .query_y_i, .query_z_i,
    .valid_o, .stall_i, .distance_o, .degenerate_o, .saturated_o
  );

  // The receiver stalls at random; the stall level for the next cycle is
  // drawn at each edge, so stalls land on every pipeline phase.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      sb.check_output(distance_o, degenerate_o, saturated_o);
      words_out++;
      if (degenerate_o) n_degen++;
      if (saturated_o) n_sat++;
    end
    stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d words pending", sb.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // A coordinate biased toward the interesting corners of the range.
  function automatic pld_pkg::coord_t pick_coord();
    case ($urandom_range(9))
      0:       return pld_pkg::coord_t'(32'h8000_0000);
      1:       return pld_pkg::coord_t'(32'h7FFF_FFFF);
      2:       return pld_pkg::coord_t'($urandom_range(7)) - 3;
      3, 4:    return pld_pkg::coord_t'($signed($urandom_range(32'h0004_0000))
                                        - 32'sh0002_0000);
      default: return pld_pkg::coord_t'($urandom());
    endcase
  endfunction

  // Presents one word, holds it until the core takes it, then leaves the
  // valid high only if the caller sends again right away.
  task automatic send_word(pld_pkg::coord_t lx, ly, lz, dx, dy, dz, qx, qy, qz);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    line_x_i  <= lx;
    line_y_i  <= ly;
    line_z_i  <= lz;
    dir_x_i   <= dx;
    dir_y_i   <= dy;
    dir_z_i   <= dz;
    query_x_i <= qx;
    query_y_i <= qy;
    query_z_i <= qz;
    do @(posedge clk_i); while (stall_o);
    sb.note_input(lx, ly, lz, dx, dy, dz, qx, qy, qz);
    words_in++;
  endtask

  task automatic send_random();
    pld_pkg::coord_t c[9];
    foreach (c[k]) c[k] = pick_coord();
    // Now and then zero the direction, or put the query on the line.
    case ($urandom_range(19))
      0: begin
        c[3] = '0;
        c[4] = '0;
        c[5] = '0;
      end
      1: begin
        c[6] = c[0];
        c[7] = c[1];
        c[8] = c[2];
      end
      default: ;
    endcase
    send_word(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
  endtask

  initial begin
    pld_pkg::coord_t mx, mn;
    mx = pld_pkg::coord_t'(32'h7FFF_FFFF);
    mn = pld_pkg::coord_t'(32'h8000_0000);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: zero direction, point on the line, unit cases and
    // extreme coordinates that drive the distance into saturation.
    send_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(mx, mn, 5, 0, 0, 0, mn, mx, 7);
    send_word(0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0);
    send_word(0, 0, 0, 0, 0, 1, 3, 4, 99);
    send_word(5, 5, 5, 1, 1, 1, 5, 5, 5);
    send_word(mx, mx, mx, 1, 0, 0, mn, mn, mn);
    send_word(mn, mn, mn, 0, 1, 0, mx, mx, mx);
    send_word(mx, mn, mx, mn, mn, mn, mn, mx, mn);
    send_word(mn, mx, mn, mx, mx, mx, mx, mn, mx);
    send_word(mx, 0, 0, 0, mn, 0, mn, 0, 0);
    send_word(0, mx, 0, 0, 0, mx, 0, mn, 0);
    send_word(1, 2, 3, mx, mx, mn, -1, -2, -3);
    send_word(-1, -1, -1, -1, -1, -1, 0, 0, 0);
    send_word(0, 0, 0, 1, 0, 0, 0, 0, -1);
    send_word(mn, 0, 0, mn, 0, 0, mx, mx, 0);

    // Random words in three idle phases.
    send_idle_pct = 38;
    recv_idle_pct = 74;
    repeat (320) send_random();
    send_idle_pct = 74;
    recv_idle_pct = 38;
    repeat (320) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (310) send_random();
    valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Run covered %0d words in, %0d out, %0d degenerate, %0d saturated,",
             words_in, words_out, n_degen, n_sat);
    $display("under sender-side and receiver-side stalls and free streaming.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

>>> point_line_distance_3d_core.f
rtl/pld_pkg.sv
rtl/pld_cross.sv
rtl/pld_norm.sv
rtl/pld_root.sv
rtl/point_line_distance_3d_core.sv
rtl/pld_checker.sv
tb/sv/point_line_distance_3d_core_test.sv
